>>> src/pma_pkg.sv
// ----------------------------------------------------------------------------
// pma_pkg: pointer momentum accelerator shared types and constants
// Item layouts, register indexes, reset values and divide-by-100 constants.
// ----------------------------------------------------------------------------
package pma_pkg;

  typedef struct packed {
    logic signed [7:0] dx;
    logic signed [7:0] dy;
    logic [31:0]       now_ms;
  } in_item_t;

  typedef struct packed {
    logic signed [7:0] scaled_dx;
    logic signed [7:0] scaled_dy;
    logic              layer_active;
    logic [10:0]       momentum_pct;
  } out_item_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MOTION_THRESHOLD = 3'd0,
    CFG_LAYER_TIMEOUT    = 3'd1,
    CFG_FAST_INTERVAL    = 3'd2,
    CFG_MOMENTUM_STEP    = 3'd3,
    CFG_MOMENTUM_DECAY   = 3'd4,
    CFG_MOMENTUM_MIN     = 3'd5,
    CFG_MOMENTUM_MAX     = 3'd6
  } cfg_idx_t;

  // register reset values
  localparam logic [7:0]  RST_MOTION_THRESHOLD = 8'd5;
  localparam logic [15:0] RST_LAYER_TIMEOUT    = 16'd1000;
  localparam logic [15:0] RST_FAST_INTERVAL    = 16'd50;
  localparam logic [7:0]  RST_MOMENTUM_STEP    = 8'd15;
  localparam logic [7:0]  RST_MOMENTUM_DECAY   = 8'd4;
  localparam logic [10:0] RST_MOMENTUM_MIN     = 11'd80;
  localparam logic [10:0] RST_MOMENTUM_MAX     = 11'd1500;
  localparam logic [10:0] RST_MOMENTUM_LEVEL   = 11'd100;

  // divide by 100: products at or above SAT_LIMIT saturate to 127,
  // below it floor(p * DIV_RECIP >> DIV_SHIFT) == p / 100 exactly
  localparam logic [18:0] SAT_LIMIT = 19'd12800;
  localparam logic [13:0] DIV_RECIP = 14'd10486;
  localparam int          DIV_SHIFT = 20;
  localparam logic [6:0]  AXIS_MAX  = 7'd127;

endpackage

>>> src/pointer_momentum_accel.sv
// ----------------------------------------------------------------------------
// pointer_momentum_accel: pointer motion momentum scaler
// Tracks a momentum percentage and a motion layer flag, scales dx/dy.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries one motion report item
//   (dx, dy, now_ms). Output channel out_valid/out_stall/out_data carries the
//   scaled report with the layer flag and the updated momentum.
//   All state (momentum, last motion time, layer flag and timer) updates in
//   the cycle the item is accepted, so reports may follow every cycle.
//   Scaling is a three-register pipeline: state update, magnitude times
//   momentum product, divide by 100 with saturation. An item moves from s1
//   to s2 to the output register, which drives out_valid. Throughput is one
//   item per cycle while out_stall is low, set by the momentum update loop.
//   A stalled output holds its item; the stages behind it keep filling, and
//   in_stall rises only when every stage holds an item.
//   Configuration writes (cfg_we/cfg_idx/cfg_wdata) take effect next cycle
//   and are meant for idle periods. Synchronous reset restores register
//   defaults, momentum 100, layer off, and empties the pipeline.
// ----------------------------------------------------------------------------
module pointer_momentum_accel (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  pma_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output pma_pkg::out_item_t                  out_data,
  input  logic                                cfg_we,
  input  logic [pma_pkg::CFG_IDX_W-1:0]       cfg_idx,
  input  logic [pma_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  // configuration registers
  logic [7:0]  thr_r;
  logic [15:0] timeout_r;
  logic [15:0] fast_r;
  logic [7:0]  step_r;
  logic [7:0]  decay_r;
  logic [10:0] min_r;
  logic [10:0] max_r;

  // block state
  logic [10:0] mom_r, mom_nxt;
  logic [15:0] last_r, last_nxt;
  logic        layer_r, layer_nxt;
  logic [31:0] start_r, start_nxt;

  // pipeline registers
  logic        s1_v_r;
  logic        s1_neg_x_r, s1_neg_y_r;
  logic [7:0]  s1_mag_x_r, s1_mag_y_r;
  logic [10:0] s1_mom_r;
  logic        s1_layer_r;

  logic        s2_v_r;
  logic        s2_neg_x_r, s2_neg_y_r;
  logic [18:0] s2_prod_x_r, s2_prod_y_r;
  logic [10:0] s2_mom_r;
  logic        s2_layer_r;

  logic               out_valid_r;
  pma_pkg::out_item_t out_data_r;

  // flow control
  logic out_load, s2_load, in_accept;
  assign out_load  = !out_valid_r || !out_stall;
  assign s2_load   = !s2_v_r || out_load;
  assign in_stall  = s1_v_r && !s2_load;
  assign in_accept = in_valid && !in_stall;

  // ---- stage 1: state update ----
  logic [7:0]  mag_x, mag_y;
  logic [8:0]  mag_sum;
  logic        motion, big_move, fast;
  logic [31:0] elapsed;
  logic [15:0] gap;
  logic [11:0] grow;
  logic signed [12:0] dec;
  logic [10:0] grow_sat, dec_sat;

  assign mag_x    = in_data.dx[7] ? 8'(-in_data.dx) : 8'(in_data.dx);
  assign mag_y    = in_data.dy[7] ? 8'(-in_data.dy) : 8'(in_data.dy);
  assign mag_sum  = {1'b0, mag_x} + {1'b0, mag_y};
  assign motion   = (in_data.dx != 8'sd0) || (in_data.dy != 8'sd0);
  assign big_move = mag_sum > {1'b0, thr_r};
  assign elapsed  = in_data.now_ms - start_r;
  assign gap      = in_data.now_ms[15:0] - last_r;
  assign fast     = gap < fast_r;
  assign grow     = {1'b0, mom_r} + {4'd0, step_r};
  assign dec      = $signed({2'b00, mom_r}) - $signed({5'd0, decay_r});
  assign grow_sat = (grow > {1'b0, max_r}) ? max_r : grow[10:0];
  assign dec_sat  = (dec < $signed({2'b00, min_r})) ? min_r : dec[10:0];

  always_comb begin
    start_nxt = big_move ? in_data.now_ms : start_r;
    // a restarted timer has zero elapsed time, so it cannot expire here
    layer_nxt = big_move || (layer_r && (elapsed <= {16'd0, timeout_r}));
    last_nxt  = motion ? in_data.now_ms[15:0] : last_r;
    if (motion) begin
      mom_nxt = fast ? grow_sat : dec_sat;
    end else if (mom_r > min_r) begin
      mom_nxt = dec_sat;
    end else begin
      mom_nxt = mom_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= pma_pkg::RST_MOTION_THRESHOLD;
      timeout_r <= pma_pkg::RST_LAYER_TIMEOUT;
      fast_r    <= pma_pkg::RST_FAST_INTERVAL;
      step_r    <= pma_pkg::RST_MOMENTUM_STEP;
      decay_r   <= pma_pkg::RST_MOMENTUM_DECAY;
      min_r     <= pma_pkg::RST_MOMENTUM_MIN;
      max_r     <= pma_pkg::RST_MOMENTUM_MAX;
    end else if (cfg_we) begin
      case (cfg_idx)
        pma_pkg::CFG_MOTION_THRESHOLD: thr_r     <= cfg_wdata[7:0];
        pma_pkg::CFG_LAYER_TIMEOUT:    timeout_r <= cfg_wdata;
        pma_pkg::CFG_FAST_INTERVAL:    fast_r    <= cfg_wdata;
        pma_pkg::CFG_MOMENTUM_STEP:    step_r    <= cfg_wdata[7:0];
        pma_pkg::CFG_MOMENTUM_DECAY:   decay_r   <= cfg_wdata[7:0];
        pma_pkg::CFG_MOMENTUM_MIN:     min_r     <= cfg_wdata[10:0];
        pma_pkg::CFG_MOMENTUM_MAX:     max_r     <= cfg_wdata[10:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mom_r   <= pma_pkg::RST_MOMENTUM_LEVEL;
      last_r  <= '0;
      layer_r <= 1'b0;
      start_r <= '0;
    end else if (in_accept) begin
      mom_r   <= mom_nxt;
      last_r  <= last_nxt;
      layer_r <= layer_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s2_load) begin
      s1_v_r <= in_accept;
    end else if (in_accept) begin
      s1_v_r <= 1'b1;
    end
    if (in_accept) begin
      s1_neg_x_r <= in_data.dx[7];
      s1_neg_y_r <= in_data.dy[7];
      s1_mag_x_r <= mag_x;
      s1_mag_y_r <= mag_y;
      s1_mom_r   <= mom_nxt;
      s1_layer_r <= layer_nxt;
    end
  end

  // ---- stage 2: magnitude times momentum ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_load) begin
      s2_v_r <= s1_v_r;
    end
    if (s2_load && s1_v_r) begin
      s2_neg_x_r  <= s1_neg_x_r;
      s2_neg_y_r  <= s1_neg_y_r;
      s2_prod_x_r <= {11'd0, s1_mag_x_r} * {8'd0, s1_mom_r};
      s2_prod_y_r <= {11'd0, s1_mag_y_r} * {8'd0, s1_mom_r};
      s2_mom_r    <= s1_mom_r;
      s2_layer_r  <= s1_layer_r;
    end
  end

  // ---- stage 3: divide by 100, saturate, restore sign ----
  function automatic logic signed [7:0] scale_axis(input logic [18:0] prod,
                                                   input logic neg);
    logic [27:0] q;
    logic [6:0]  m;
    q = {14'd0, prod[13:0]} * {14'd0, pma_pkg::DIV_RECIP};
    m = (prod >= pma_pkg::SAT_LIMIT) ? pma_pkg::AXIS_MAX
                                     : q[pma_pkg::DIV_SHIFT+6:pma_pkg::DIV_SHIFT];
    return neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= s2_v_r;
    end
    if (out_load && s2_v_r) begin
      out_data_r.scaled_dx    <= scale_axis(s2_prod_x_r, s2_neg_x_r);
      out_data_r.scaled_dy    <= scale_axis(s2_prod_y_r, s2_neg_y_r);
      out_data_r.layer_active <= s2_layer_r;
      out_data_r.momentum_pct <= s2_mom_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // ---- assertions ----
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_v_r && s2_v_r && out_valid_r))
    else $error("input stalled with a free stage");

  a_no_neg_full_scale: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.scaled_dx != -8'sd128 &&
                     out_data_r.scaled_dy != -8'sd128))
    else $error("scaled axis outside +-127");

  a_big_move_sets_layer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && big_move) |=> layer_r)
    else $error("large motion did not set the layer flag");

  a_growth_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && motion && fast) |=> (mom_r <= $past(max_r)))
    else $error("momentum grew past max");

  a_idle_at_min_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !motion && (mom_r <= min_r)) |=> $stable(mom_r))
    else $error("idle momentum at or below min changed");

endmodule
